// ===== sv/rqma_pkg.sv =====
// rqma_pkg: item types, constants and the segment lookup for the read
// quality mask and average block
// depends on nothing; used by every module of the block
package rqma_pkg;

    // quality encoding and read layout
    localparam logic [6:0] QUAL_OFFSET = 7'd33;
    localparam logic [7:0] MASK_CHAR   = 8'd46;
    localparam logic [6:0] READ_LEN    = 7'd70;
    localparam logic [6:0] HALF_LEN    = 7'd35;
    localparam logic [6:0] FIRST_SEG   = 7'd5;
    localparam logic [6:0] SEG_LEN     = 7'd10;
    localparam int         MID_SEGS    = 6;

    // reciprocal of 35 scaled by 2^17, rounded up
    localparam int         RECIP_SHIFT = 17;
    localparam logic [11:0] RECIP_35   = 12'd3745;

    // widths of the running sums
    localparam int SUM_W   = 12;
    localparam int TOTAL_W = 13;

    typedef struct packed {
        logic [7:0] base;
        logic [6:0] quality;
        logic       last_position;
    } t_in_item;

    typedef struct packed {
        logic [7:0] masked_base;
        logic [2:0] segment_index;
        logic [3:0] offset_in_segment;
        logic       read_done;
        logic [6:0] average_quality;
        logic [6:0] average_left;
        logic [6:0] average_right;
        logic       length_ok;
    } t_out_item;

    typedef struct packed {
        logic [2:0] seg;
        logic [3:0] off;
    } t_seg_pos;

    // segment and offset of a read position in the 5,10x6,5 layout
    function automatic t_seg_pos locate(input logic [6:0] pos);
        t_seg_pos   loc;
        logic [6:0] start;
        logic [6:0] bound;
        loc   = '0;
        start = '0;
        bound = '0;
        if (pos < READ_LEN) begin
            if (pos >= FIRST_SEG) begin
                loc.seg = 3'd1;
                start   = FIRST_SEG;
            end
            // each middle boundary moves the segment up by one
            for (int k = 1; k <= MID_SEGS; k++) begin
                bound = 7'(FIRST_SEG + SEG_LEN * k);
                if (pos >= bound) begin
                    loc.seg = 3'(k + 1);
                    start   = bound;
                end
            end
            loc.off = 4'(pos - start);
        end
        return loc;
    endfunction

endpackage

// ===== sv/read_quality_mask_and_average.sv =====
// read_quality_mask_and_average: top level of the read quality mask block
// depends on rqma_pkg and rqma_div35
//
// One item is one read position (base and Phred+33 quality). Every input
// item gives one result item. An item is taken in every unstalled cycle;
// items pass two registered stages: the first stage masks the base, tags
// its segment and adds the quality into the left or right half sum; the
// second stage turns the sums into averages with a reciprocal multiply on
// the item marked last. Bases with quality below mask_threshold + 33 come
// out as '.'. Positions past 70 are masked but not summed and carry
// segment 0, offset 0. The averages always divide by 70 and 35; length_ok
// shows whether the read held exactly 70 positions. The user must write
// the threshold via i_cfg_we / i_cfg_data only while idle (not enforced).
module read_quality_mask_and_average (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [6:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rqma_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rqma_pkg::t_out_item o_out_item
);

    typedef struct packed {
        logic [7:0]                  masked_base;
        logic [2:0]                  seg;
        logic [3:0]                  off;
        logic                        last;
        logic                        len_ok;
        logic [rqma_pkg::SUM_W-1:0]  left_sum;
        logic [rqma_pkg::SUM_W-1:0]  right_sum;
    } t_mid;

    logic [6:0]                 r_mask_threshold;
    logic [6:0]                 r_pos;
    logic [6:0]                 n_pos;
    logic [rqma_pkg::SUM_W-1:0] r_left;
    logic [rqma_pkg::SUM_W-1:0] r_right;
    logic [rqma_pkg::SUM_W-1:0] n_left;
    logic [rqma_pkg::SUM_W-1:0] n_right;
    logic                       r_s1_valid;
    t_mid                       r_s1;
    t_mid                       n_s1;
    logic                       r_s2_valid;
    rqma_pkg::t_out_item        r_s2;
    rqma_pkg::t_out_item        n_s2;
    logic                       w_out_ok;
    logic                       w_accept;
    logic [6:0]                 w_score;
    logic [7:0]                 w_limit;
    rqma_pkg::t_seg_pos         w_loc;
    logic [7:0]                 w_q_left;
    logic [7:0]                 w_q_right;
    logic [7:0]                 w_q_total;

    // pipeline flow
    assign w_out_ok    = !r_s2_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !w_out_ok;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_s2_valid;
    assign o_out_item  = r_s2;

    // mask, locate and accumulate for the incoming item
    always_comb begin
        w_limit = {1'b0, r_mask_threshold} + {1'b0, rqma_pkg::QUAL_OFFSET};
        w_score = (i_in_item.quality >= rqma_pkg::QUAL_OFFSET)
                ? i_in_item.quality - rqma_pkg::QUAL_OFFSET : 7'd0;
        w_loc   = rqma_pkg::locate(r_pos);
        n_left  = r_left;
        n_right = r_right;
        n_pos   = r_pos;
        if (r_pos < rqma_pkg::READ_LEN) begin
            if (r_pos < rqma_pkg::HALF_LEN) begin
                n_left = r_left + rqma_pkg::SUM_W'(w_score);
            end else begin
                n_right = r_right + rqma_pkg::SUM_W'(w_score);
            end
            n_pos = r_pos + 7'd1;
        end
        n_s1.masked_base = ({1'b0, i_in_item.quality} < w_limit)
                         ? rqma_pkg::MASK_CHAR : i_in_item.base;
        n_s1.seg       = w_loc.seg;
        n_s1.off       = w_loc.off;
        n_s1.last      = i_in_item.last_position;
        n_s1.len_ok    = (r_pos == rqma_pkg::READ_LEN - 7'd1);
        n_s1.left_sum  = n_left;
        n_s1.right_sum = n_right;
        // a finished read starts the next one from zero
        if (i_in_item.last_position) begin
            n_pos   = '0;
            n_left  = '0;
            n_right = '0;
        end
    end

    // averages from the sums carried with the item
    rqma_div35 u_div_left (
        .i_dividend (rqma_pkg::TOTAL_W'(r_s1.left_sum)),
        .o_quotient (w_q_left)
    );

    rqma_div35 u_div_right (
        .i_dividend (rqma_pkg::TOTAL_W'(r_s1.right_sum)),
        .o_quotient (w_q_right)
    );

    rqma_div35 u_div_total (
        .i_dividend (rqma_pkg::TOTAL_W'(r_s1.left_sum)
                   + rqma_pkg::TOTAL_W'(r_s1.right_sum)),
        .o_quotient (w_q_total)
    );

    // result fields; averages only on the last position
    always_comb begin
        n_s2.masked_base       = r_s1.masked_base;
        n_s2.segment_index     = r_s1.seg;
        n_s2.offset_in_segment = r_s1.off;
        n_s2.read_done         = r_s1.last;
        n_s2.average_quality   = r_s1.last ? w_q_total[7:1] : 7'd0;
        n_s2.average_left      = r_s1.last ? w_q_left[6:0] : 7'd0;
        n_s2.average_right     = r_s1.last ? w_q_right[6:0] : 7'd0;
        n_s2.length_ok         = r_s1.last && r_s1.len_ok;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_threshold <= '0;
            r_pos            <= '0;
            r_left           <= '0;
            r_right          <= '0;
            r_s1_valid       <= 1'b0;
            r_s2_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask_threshold <= i_cfg_data;
            end
            if (w_accept) begin
                r_pos   <= n_pos;
                r_left  <= n_left;
                r_right <= n_right;
            end
            if (!r_s1_valid || w_out_ok) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_out_ok) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_out_ok && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// ===== sv/rqma_div35.sv =====
// rqma_div35: truncating divide by 35 of a quality sum
// depends on rqma_pkg for the reciprocal constant
module rqma_div35 (
    input  logic [rqma_pkg::TOTAL_W-1:0] i_dividend,
    output logic [7:0]                   o_quotient
);

    localparam int PROD_W = rqma_pkg::TOTAL_W + 12;

    logic [PROD_W-1:0] w_prod;

    // multiply by the scaled reciprocal; exact for sums up to twice a full half
    assign w_prod = PROD_W'(i_dividend) * PROD_W'(rqma_pkg::RECIP_35);
    assign o_quotient = w_prod[rqma_pkg::RECIP_SHIFT +: 8];

endmodule
